FILE: rtl/core/ahcf_pkg.sv
// Shared types, framing constants and the hex digit encoder for the
// ascii hex checksum framer. No dependencies.
package ahcf_pkg;

   localparam logic [7:0] CHAR_STX = 8'h02;
   localparam logic [7:0] CHAR_ETX = 8'h03;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   // 'A' minus ten, so that nibble ten maps onto 'A'.
   localparam logic [7:0] CHAR_ALPHA_BASE = 8'h37;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // One classified command byte as it waits between front and back.
   typedef struct packed {
      logic [7:0] cmd_byte;
      logic       opens;
      logic       closes;
   } ahcf_entry_type;

   // Which framed byte the back end emits next for the head entry.
   typedef enum logic [2:0] {
      STEP_STX,
      STEP_BYTE,
      STEP_ETX,
      STEP_HI,
      STEP_LO,
      STEP_CR
   } ahcf_step_type;

   // Uppercase ASCII hex digit for one nibble.
   function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return CHAR_ZERO + {4'h0, nib};
      end else begin
         return CHAR_ALPHA_BASE + {4'h0, nib};
      end
   endfunction

endpackage

FILE: rtl/core/ascii_hex_checksum_framer.sv
// Top level of the STX/ETX framer with an ASCII hex checksum.
// Depends on ahcf_pkg, ahcf_front, ahcf_queue and ahcf_back.
//
// Usage: command bytes enter on the req_ channel (req_cmd_byte, with
// req_cmd_last on the final byte of a command); framed bytes leave on the
// rsp_ channel. Both channels are valid/ready; a transaction completes on a
// clock edge where valid and ready are both high.
// Each frame comes out as STX, the command bytes, ETX, the two uppercase hex
// digits of the 8-bit sum of STX through ETX, and CR. rsp_run_last marks the
// last output byte caused by one input transaction, rsp_frame_done the CR.
// An input transaction writes an entry into the queue; the back end then
// registers the first output byte from the queue head and raises rsp_valid.
// The back end emits one output byte per cycle while the queue holds an entry
// and the receiver does not stall. A middle command byte yields one byte, a
// frame opener adds STX and a closing byte adds ETX, two hex digits and CR;
// the front end absorbs the difference in the entry queue.
// When the receiver stalls, the output register holds its byte and the
// queue keeps filling; req_ready drops only when the queue is full.
// Synchronous reset closes any open frame, clears the checksum, empties the
// queue and drops rsp_valid.
module ascii_hex_checksum_framer #(
   parameter int QUEUE_DEPTH = ahcf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_cmd_byte,
   input  logic       req_cmd_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_frame_done
);
   import ahcf_pkg::*;

   // Classified entries travel from the front end into the queue.
   ahcf_entry_type push_entry;
   ahcf_entry_type head_entry;
   logic           push;
   logic           pop;
   logic           queue_empty;
   logic           queue_full;

   ahcf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd_byte (req_cmd_byte),
      .req_cmd_last (req_cmd_last),
      .queue_full   (queue_full),
      .push         (push),
      .entry        (push_entry)
   );

   ahcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   // The back end pops an entry once its last framed byte is registered.
   ahcf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_entry     (head_entry),
      .queue_empty    (queue_empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

FILE: rtl/core/ahcf_front.sv
// Front end of the framer: accepts command bytes and marks frame openers and closers.
// Depends on ahcf_pkg.
module ahcf_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_cmd_byte,
   input  logic                    req_cmd_last,
   input  logic                    queue_full,
   output logic                    push,
   output ahcf_pkg::ahcf_entry_type entry
);
   import ahcf_pkg::*;

   logic in_frame_ff;
   logic in_frame_in;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   // A byte opens a frame when none is open; a last byte closes it again.
   assign entry.cmd_byte = req_cmd_byte;
   assign entry.opens    = !in_frame_ff;
   assign entry.closes   = req_cmd_last;

   always_comb begin
      in_frame_in = in_frame_ff;
      if (push) begin
         in_frame_in = !req_cmd_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

FILE: rtl/core/ahcf_queue.sv
// Small FIFO of classified entries between the front and back ends.
// Depends on ahcf_pkg.
module ahcf_queue #(
   parameter int DEPTH = ahcf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ahcf_pkg::ahcf_entry_type push_entry,
   input  logic                    pop,
   output ahcf_pkg::ahcf_entry_type head_entry,
   output logic                    empty,
   output logic                    full
);
   import ahcf_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ahcf_entry_type    slot_ff [DEPTH];
   logic [IW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CW'(DEPTH));
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/core/ahcf_back.sv
// Back end of the framer: steps through the framed bytes of each entry,
// keeps the checksum and holds the result in an output register.
// Depends on ahcf_pkg.
module ahcf_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ahcf_pkg::ahcf_entry_type head_entry,
   input  logic                    queue_empty,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_run_last,
   output logic                    rsp_frame_done
);
   import ahcf_pkg::*;

   ahcf_step_type step_ff, step_in, cur_step;
   logic [7:0]    sum_ff, sum_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_run_last_ff, rsp_run_last_in;
   logic          rsp_done_ff, rsp_done_in;
   logic          fire;

   assign fire = !queue_empty && (!rsp_valid_ff || rsp_ready);

   // STX is only emitted for an entry that opens a frame.
   assign cur_step = (step_ff == STEP_STX && !head_entry.opens) ? STEP_BYTE : step_ff;

   // Next state.
   always_comb begin
      step_in = step_ff;
      if (fire) begin
         unique case (cur_step)
            STEP_STX:  step_in = STEP_BYTE;
            STEP_BYTE: step_in = head_entry.closes ? STEP_ETX : STEP_STX;
            STEP_ETX:  step_in = STEP_HI;
            STEP_HI:   step_in = STEP_LO;
            STEP_LO:   step_in = STEP_CR;
            STEP_CR:   step_in = STEP_STX;
            default:   step_in = STEP_STX;
         endcase
      end
   end

   // Outputs of the sequencer.
   always_comb begin
      rsp_byte_in     = rsp_byte_ff;
      rsp_run_last_in = rsp_run_last_ff;
      rsp_done_in     = rsp_done_ff;
      sum_in          = sum_ff;
      pop             = 1'b0;
      if (fire) begin
         rsp_run_last_in = 1'b0;
         rsp_done_in     = 1'b0;
         unique case (cur_step)
            STEP_STX: begin
               rsp_byte_in = CHAR_STX;
               sum_in      = CHAR_STX;
            end
            STEP_BYTE: begin
               rsp_byte_in     = head_entry.cmd_byte;
               sum_in          = sum_ff + head_entry.cmd_byte;
               rsp_run_last_in = !head_entry.closes;
               pop             = !head_entry.closes;
            end
            STEP_ETX: begin
               rsp_byte_in = CHAR_ETX;
               sum_in      = sum_ff + CHAR_ETX;
            end
            STEP_HI: begin
               rsp_byte_in = hex_ascii(sum_ff[7:4]);
            end
            STEP_LO: begin
               rsp_byte_in = hex_ascii(sum_ff[3:0]);
            end
            STEP_CR: begin
               rsp_byte_in     = CHAR_CR;
               sum_in          = '0;
               rsp_run_last_in = 1'b1;
               rsp_done_in     = 1'b1;
               pop             = 1'b1;
            end
            default: begin
               rsp_byte_in = CHAR_CR;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_STX;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff     <= rsp_byte_in;
      rsp_run_last_ff <= rsp_run_last_in;
      rsp_done_ff     <= rsp_done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_run_last   = rsp_run_last_ff;
   assign rsp_frame_done = rsp_done_ff;

endmodule

FILE: rtl/core/ahcf_checker.sv
// Port-level checker for the framer, bound to its top level.
// Depends on ahcf_pkg and ascii_hex_checksum_framer.
module ahcf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_frame_done
);
   import ahcf_pkg::*;

   // A frame always ends on CR, which also ends its input transaction.
   a_done_is_cr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_out_byte == CHAR_CR && rsp_run_last)
      else $error("frame_done on a byte other than a final CR");

   // The closing CR follows the low checksum digit directly, which is never
   // a run-last byte; a CR held by a stall shows itself the cycle before.
   a_done_after_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_frame_done |->
         $past(rsp_valid) && (!$past(rsp_run_last) || $past(rsp_frame_done)))
      else $error("closing CR not preceded by a checksum digit");

   a_idle_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte) && $stable(rsp_run_last)
         && $stable(rsp_frame_done))
      else $error("rsp payload changed while stalled");

endmodule

bind ascii_hex_checksum_framer ahcf_checker u_ahcf_checker (.*);
